>>> sv/line_line_intersection_3d_unit_assert.svh
// Assertion macros for the line-line intersection unit checker
`ifndef LINE_LINE_INTERSECTION_3D_UNIT_ASSERT_SVH
`define LINE_LINE_INTERSECTION_3D_UNIT_ASSERT_SVH

// same-cycle implication
`define LLI3_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lli3 port check failed");

// next-cycle implication
`define LLI3_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lli3 port check failed");

`endif

>>> sv/lli3_pkg.sv
// Shared types and pipeline depths for the line-line intersection unit
package lli3_pkg;

	localparam int DIV_BITS    = 33;
	localparam int FRONT_DEPTH = 4;
	localparam int LANE_DEPTH  = DIV_BITS + 4;
	localparam int TOTAL_DEPTH = FRONT_DEPTH + LANE_DEPTH;

	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		logic [65:0] num_abs;
		logic [64:0] den_abs;
		logic        neg;
		logic        par;
	} lane_in_t;

endpackage

>>> sv/lli3_lane.sv
// One output coordinate: scale, overflow check, pipelined divide, offset and clamp
module lli3_lane import lli3_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  lane_in_t lin,
	input  coord_t   p1,
	input  coord_t   d1,
	output coord_t   meet,
	output logic     par
);

	logic [31:0] mag;
	assign mag = d1[31] ? 32'(-d1) : 32'(d1);

	// stage 1: partial products of |num| * |d1|
	logic [64:0] pplo_s1, pphi_s1;
	logic [64:0] den_s1;
	logic        neg_s1, par_s1;
	coord_t      p1_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pplo_s1 <= 65'(lin.num_abs[32:0] * mag);
			pphi_s1 <= 65'(lin.num_abs[65:33] * mag);
			den_s1  <= lin.den_abs;
			neg_s1  <= lin.neg ^ d1[31];
			par_s1  <= lin.par;
			p1_s1   <= p1;
		end
	end

	// stage 2: combine into the dividend
	logic [97:0] n_s2;
	logic [64:0] den_s2;
	logic        neg_s2, par_s2;
	coord_t      p1_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2   <= {33'd0, pplo_s1} + {pphi_s1, 33'd0};
			den_s2 <= den_s1;
			neg_s2 <= neg_s1;
			par_s2 <= par_s1;
			p1_s2  <= p1_s1;
		end
	end

	// stage 3 and divide stages share arrays; index 0 is stage 3
	logic [97:0]         rem_d [DIV_BITS+1];
	logic [DIV_BITS-1:0] quo_d [DIV_BITS+1];
	logic [64:0]         den_d [DIV_BITS+1];
	logic                neg_d [DIV_BITS+1];
	logic                par_d [DIV_BITS+1];
	logic                ovf_d [DIV_BITS+1];
	coord_t              p1_d  [DIV_BITS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_d[0] <= n_s2;
			quo_d[0] <= '0;
			den_d[0] <= den_s2;
			neg_d[0] <= neg_s2;
			par_d[0] <= par_s2;
			// quotient would not fit in the divide stages: clamp instead
			ovf_d[0] <= n_s2 >= {den_s2, 33'd0};
			p1_d[0]  <= p1_s2;
		end
	end

	for (genvar i = 1; i <= DIV_BITS; i++) begin : g_div
		localparam int J = DIV_BITS - i;
		logic [97:0] sub;
		logic        ge;
		assign sub = {33'd0, den_d[i-1]} << J;
		assign ge  = rem_d[i-1] >= sub;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_d[i] <= ge ? rem_d[i-1] - sub : rem_d[i-1];
				quo_d[i] <= quo_d[i-1] | (DIV_BITS'(ge) << J);
				den_d[i] <= den_d[i-1];
				neg_d[i] <= neg_d[i-1];
				par_d[i] <= par_d[i-1];
				ovf_d[i] <= ovf_d[i-1];
				p1_d[i]  <= p1_d[i-1];
			end
		end
	end

	// final stage: offset by p1 and clamp
	logic signed [34:0] qs, sum;
	coord_t             res;
	assign qs  = neg_d[DIV_BITS] ? -$signed({2'b00, quo_d[DIV_BITS]})
	                             : $signed({2'b00, quo_d[DIV_BITS]});
	assign sum = 35'(p1_d[DIV_BITS]) + qs;

	always_comb begin
		if (par_d[DIV_BITS]) begin
			res = '0;
		end else if (ovf_d[DIV_BITS]) begin
			res = neg_d[DIV_BITS] ? 32'sh80000000 : 32'sh7fffffff;
		end else if (sum > 35'sh7fffffff) begin
			res = 32'sh7fffffff;
		end else if (sum < -35'sh80000000) begin
			res = 32'sh80000000;
		end else begin
			res = sum[31:0];
		end
	end

	coord_t meet_sf;
	logic   par_sf;

	always_ff @(posedge clk) begin
		if (en) begin
			meet_sf <= res;
			par_sf  <= par_d[DIV_BITS];
		end
	end

	assign meet = meet_sf;
	assign par  = par_sf;

endmodule

>>> sv/line_line_intersection_3d_unit.sv
// Throughput: one word per cycle while unstalled; the 33-stage restoring divider
// in each lane takes one quotient bit per stage and sets the depth.
// A stalled output holds the whole pipeline; in_ready follows out_ready then.
// Reset (arst_n low) clears all valid bits; data registers are not reset.
module line_line_intersection_3d_unit import lli3_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  coord_t first_point_x,
	input  coord_t first_point_y,
	input  coord_t first_point_z,
	input  coord_t first_dir_x,
	input  coord_t first_dir_y,
	input  coord_t first_dir_z,
	input  coord_t second_point_x,
	input  coord_t second_point_y,
	input  coord_t second_point_z,
	input  coord_t second_dir_x,
	input  coord_t second_dir_y,
	input  coord_t second_dir_z,
	output logic   out_valid,
	input  logic   out_ready,
	output coord_t meet_x,
	output coord_t meet_y,
	output coord_t meet_z,
	output logic   parallel_flag
);

	logic en;
	logic vld_s [1:TOTAL_DEPTH];

	assign en       = !vld_s[TOTAL_DEPTH] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_s[TOTAL_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= TOTAL_DEPTH; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= TOTAL_DEPTH; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	coord_t p1 [3], d1 [3], p2 [3], d2 [3];
	assign p1[0] = first_point_x;
	assign p1[1] = first_point_y;
	assign p1[2] = first_point_z;
	assign d1[0] = first_dir_x;
	assign d1[1] = first_dir_y;
	assign d1[2] = first_dir_z;
	assign p2[0] = second_point_x;
	assign p2[1] = second_point_y;
	assign p2[2] = second_point_z;
	assign d2[0] = second_dir_x;
	assign d2[1] = second_dir_y;
	assign d2[2] = second_dir_z;

	// stage 1: cross product terms, w = p2 - p1
	logic signed [63:0] pa_s1 [3], pb_s1 [3];
	logic signed [32:0] w_s1 [3];
	coord_t             p1_s1 [3], d1_s1 [3], d2_s1 [3];

	// stage 2: cross product, numerator terms for every axis
	logic signed [64:0] n_s2 [3], qa_s2 [3], qb_s2 [3];
	coord_t             p1_s2 [3], d1_s2 [3];

	// stage 3: numerators, magnitudes
	logic signed [65:0] num_s3 [3];
	logic        [64:0] nabs_s3 [3];
	logic               nneg_s3 [3];
	logic               par_s3;
	coord_t             p1_s3 [3], d1_s3 [3];

	for (genvar k = 0; k < 3; k++) begin : g_axis
		localparam int U = (k + 1) % 3;
		localparam int V = (k + 2) % 3;

		always_ff @(posedge clk) begin
			if (en) begin
				pa_s1[k] <= d1[U] * d2[V];
				pb_s1[k] <= d1[V] * d2[U];
				w_s1[k]  <= 33'(p2[k]) - 33'(p1[k]);
				p1_s1[k] <= p1[k];
				d1_s1[k] <= d1[k];
				d2_s1[k] <= d2[k];

				n_s2[k]  <= 65'(pa_s1[k]) - 65'(pb_s1[k]);
				qa_s2[k] <= w_s1[U] * d2_s1[V];
				qb_s2[k] <= w_s1[V] * d2_s1[U];
				p1_s2[k] <= p1_s1[k];
				d1_s2[k] <= d1_s1[k];

				num_s3[k]  <= 66'(qa_s2[k]) - 66'(qb_s2[k]);
				nabs_s3[k] <= n_s2[k][64] ? 65'(-n_s2[k]) : 65'(n_s2[k]);
				nneg_s3[k] <= n_s2[k][64];
				p1_s3[k]   <= p1_s2[k];
				d1_s3[k]   <= d1_s2[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			par_s3 <= (n_s2[0] == '0) && (n_s2[1] == '0) && (n_s2[2] == '0);
		end
	end

	// stage 4: pick the axis of largest |n|, ties to the lower axis
	logic [1:0]         ksel;
	logic signed [65:0] num_sel;
	logic [65:0]        num_abs;

	always_comb begin
		if (nabs_s3[0] >= nabs_s3[1] && nabs_s3[0] >= nabs_s3[2]) begin
			ksel = 2'd0;
		end else if (nabs_s3[1] >= nabs_s3[2]) begin
			ksel = 2'd1;
		end else begin
			ksel = 2'd2;
		end
	end

	assign num_sel = num_s3[ksel];
	assign num_abs = num_sel[65] ? 66'(-num_sel) : 66'(num_sel);

	lane_in_t lin_s4;
	coord_t   p1_s4 [3], d1_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s4.num_abs <= num_abs;
			lin_s4.den_abs <= nabs_s3[ksel];
			lin_s4.neg     <= num_sel[65] ^ nneg_s3[ksel];
			lin_s4.par     <= par_s3;
			for (int i = 0; i < 3; i++) begin
				p1_s4[i] <= p1_s3[i];
				d1_s4[i] <= d1_s3[i];
			end
		end
	end

	coord_t meet [3];
	logic   par_lane [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		lli3_lane u_lane (
			.clk  (clk),
			.en   (en),
			.lin  (lin_s4),
			.p1   (p1_s4[i]),
			.d1   (d1_s4[i]),
			.meet (meet[i]),
			.par  (par_lane[i])
		);
	end

	assign meet_x        = meet[0];
	assign meet_y        = meet[1];
	assign meet_z        = meet[2];
	assign parallel_flag = par_lane[0] & par_lane[1] & par_lane[2];

endmodule

>>> sv/lli3_chk.sv
// Port checker for the line-line intersection unit, bound to the top level
`include "line_line_intersection_3d_unit_assert.svh"

module lli3_chk import lli3_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input coord_t meet_x,
	input coord_t meet_y,
	input coord_t meet_z,
	input logic   parallel_flag
);

	`LLI3_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`LLI3_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(meet_x) && $stable(meet_y) && $stable(meet_z) && $stable(parallel_flag))
	`LLI3_ASSERT_IMP(a_par_origin, out_valid && parallel_flag, meet_x == 0 && meet_y == 0 && meet_z == 0)
	`LLI3_ASSERT_IMP(a_ready_stall, !in_ready, out_valid && !out_ready)

endmodule

bind line_line_intersection_3d_unit lli3_chk u_lli3_chk (.*);
